// ----- sv/mro_pkg.sv -----
// Shared constants, opcodes and controller/datapath command and status types
// for the max-min representative ordering block. No dependencies.
package mro_pkg;

  localparam int unsigned MAX_POINTS_DEF     = 64;
  localparam int unsigned DIST_FRAC_BITS_DEF = 15;

  localparam logic [1:0] OP_LOAD_POINT = 2'd0;
  localparam logic [1:0] OP_LOAD_DIST  = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  typedef struct packed {
    logic load_point;
    logic load_dist;
    logic run_start;
    logic pass_start;
    logic scan;
    logic update;
    logic pick;
    logic next_rank;
  } mro_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic last_rank;
    logic n_zero;
  } mro_status_t;

endpackage

// ----- sv/mro_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mro_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/mro_ctrl.sv -----
// Controller state machine: sequences load, scan, emit and update passes.
// Depends on mro_pkg.
module mro_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mro_pkg::mro_status_t status_i,
  output mro_pkg::mro_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_o;
    cmd_o       = '0;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.update = (state_q == ST_UPD);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_point = (in_op_i == mro_pkg::OP_LOAD_POINT);
          cmd_o.load_dist  = (in_op_i == mro_pkg::OP_LOAD_DIST);
          if (in_op_i == mro_pkg::OP_RUN && !status_i.n_zero) begin
            cmd_o.run_start = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.pass_done) begin
          cmd_o.pick  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (status_i.last_rank) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pass_start = 1'b1;
            state_d          = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (status_i.pass_done) begin
          cmd_o.pass_start = 1'b1;
          cmd_o.next_rank  = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= out_valid_d;
    end
  end

endmodule

// ----- sv/mro_dp.sv -----
// Datapath: point, distance and nearest-distance memories, chosen mask,
// slot pass counter and best-candidate registers. Depends on mro_pkg, mro_ram.
module mro_dp #(
  parameter int unsigned MAX_POINTS     = mro_pkg::MAX_POINTS_DEF,
  parameter int unsigned DIST_FRAC_BITS = mro_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mro_pkg::mro_cmd_t    cmd_i,
  output mro_pkg::mro_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_data_i,
  input  logic [5:0]           point_slot_i,
  input  logic [15:0]          point_ident_i,
  input  logic [15:0]          dominated_size_i,
  input  logic [5:0]           row_slot_i,
  input  logic [5:0]           col_slot_i,
  input  logic [15:0]          jaccard_value_i,
  output logic [15:0]          chosen_ident_o,
  output logic [5:0]           rank_position_o,
  output logic                 final_flag_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned DAW = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int unsigned DW  = DIST_FRAC_BITS + 1;
  localparam int unsigned NW  = DW + 1;
  localparam logic [31:0] DIST_CAP = 32'((64'd1 << DW) - 64'd1);
  localparam logic [NW-1:0] NEAR_INIT = {1'b1, {DW{1'b0}}};

  logic [6:0]            point_count_q;
  logic [6:0]            n_q;
  logic [6:0]            n_run;
  logic [6:0]            cnt_q;
  logic [6:0]            rank_q;
  logic                  pipe_q;
  logic [AW-1:0]         pslot_q;
  logic                  issue;
  logic [MAX_POINTS-1:0] chosen_q;
  logic [MAX_POINTS-1:0] nvalid_q;
  logic                  have_q;
  logic [AW-1:0]         bslot_q;
  logic [15:0]           bident_q;
  logic [15:0]           bsize_q;
  logic [NW-1:0]         bnear_q;

  logic [31:0]           pt_rdata;
  logic [DW-1:0]         dist_rdata;
  logic [NW-1:0]         near_rdata;
  logic [NW-1:0]         near_eff;
  logic [15:0]           c_ident;
  logic [15:0]           c_size;
  logic                  wins;
  logic                  take;
  logic                  near_we;
  logic                  pt_ok;
  logic                  dist_ok;
  logic [31:0]           jv;
  logic [31:0]           jsat;
  logic [DAW-1:0]        dist_waddr;
  logic [DAW-1:0]        dist_raddr;

  assign n_run = (point_count_q > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count_q;

  assign status_o.n_zero    = (n_run == 7'd0);
  assign status_o.pass_done = (cnt_q == n_q) && !pipe_q;
  assign status_o.last_rank = ((rank_q + 7'd1) == n_q);

  assign issue = (cmd_i.scan || cmd_i.update) && (cnt_q < n_q);

  assign pt_ok   = (7'(point_slot_i) < 7'(MAX_POINTS));
  assign dist_ok = (7'(row_slot_i) < 7'(MAX_POINTS)) && (7'(col_slot_i) < 7'(MAX_POINTS));
  assign jv      = 32'(jaccard_value_i);
  assign jsat    = (jv > DIST_CAP) ? DIST_CAP : jv;

  assign dist_waddr = DAW'(row_slot_i[AW-1:0]) * DAW'(MAX_POINTS) + DAW'(col_slot_i[AW-1:0]);
  assign dist_raddr = DAW'(cnt_q[AW-1:0]) * DAW'(MAX_POINTS) + DAW'(bslot_q);

  mro_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_point && pt_ok),
    .waddr_i (point_slot_i[AW-1:0]),
    .wdata_i ({dominated_size_i, point_ident_i}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (pt_rdata)
  );

  mro_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS * MAX_POINTS)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_dist && dist_ok),
    .waddr_i (dist_waddr),
    .wdata_i (jsat[DW-1:0]),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  assign near_eff = nvalid_q[pslot_q] ? near_rdata : NEAR_INIT;
  assign near_we  = cmd_i.update && pipe_q && !chosen_q[pslot_q] &&
                    ({1'b0, dist_rdata} < near_eff);

  mro_ram #(.WIDTH(NW), .DEPTH(MAX_POINTS)) u_near_ram (
    .clk_i   (clk_i),
    .we_i    (near_we),
    .waddr_i (pslot_q),
    .wdata_i ({1'b0, dist_rdata}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (near_rdata)
  );

  assign c_ident = pt_rdata[15:0];
  assign c_size  = pt_rdata[31:16];
  assign wins    = (c_size != bsize_q) ? (c_size > bsize_q) : (c_ident < bident_q);

  always_comb begin
    take = 1'b0;
    if (cmd_i.scan && pipe_q && !chosen_q[pslot_q]) begin
      if (!have_q) begin
        take = 1'b1;
      end else if (rank_q == 7'd0) begin
        take = wins;
      end else begin
        take = (near_eff > bnear_q) || ((near_eff == bnear_q) && wins);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 7'd1;
      n_q           <= '0;
      cnt_q         <= '0;
      rank_q        <= '0;
      pipe_q        <= 1'b0;
      chosen_q      <= '0;
      nvalid_q      <= '0;
      have_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        point_count_q <= cfg_data_i;
      end
      pipe_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 7'd1;
      end
      if (take) begin
        have_q <= 1'b1;
      end
      if (near_we) begin
        nvalid_q[pslot_q] <= 1'b1;
      end
      if (cmd_i.pick) begin
        chosen_q[bslot_q] <= 1'b1;
      end
      if (cmd_i.pass_start) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end
      if (cmd_i.next_rank) begin
        rank_q <= rank_q + 7'd1;
      end
      if (cmd_i.run_start) begin
        n_q      <= n_run;
        cnt_q    <= '0;
        rank_q   <= '0;
        chosen_q <= '0;
        nvalid_q <= '0;
        have_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pslot_q <= cnt_q[AW-1:0];
    if (take) begin
      bslot_q  <= pslot_q;
      bident_q <= c_ident;
      bsize_q  <= c_size;
      bnear_q  <= near_eff;
    end
    if (cmd_i.pick) begin
      chosen_ident_o  <= bident_q;
      rank_position_o <= rank_q[5:0];
      final_flag_o    <= status_o.last_rank;
    end
  end

endmodule

// ----- sv/maxmin_representative_order_top.sv -----
// A run emits n points; each rank scans the point and nearest-distance
// memories one slot a cycle, waits for the result to be taken, then, unless
// it is the last rank, updates nearest distances. One request is worked at a
// time. Reset clears control state and sets point_count to 1. Depends on
// mro_pkg, mro_ctrl, mro_dp.
module maxmin_representative_order_top #(
  parameter int unsigned MAX_POINTS     = mro_pkg::MAX_POINTS_DEF,
  parameter int unsigned DIST_FRAC_BITS = mro_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_slot, point_ident, dominated_size, row_slot, col_slot, jaccard_value
  input  logic [71:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_ident, rank_position
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  mro_pkg::mro_cmd_t    cmd;
  mro_pkg::mro_status_t status;
  logic [15:0]          chosen_ident;
  logic [5:0]           rank_position;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {2'b00, rank_position, chosen_ident};

  mro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mro_dp #(
    .MAX_POINTS     (MAX_POINTS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .point_slot_i     (s_axis_tdata[5:0]),
    .point_ident_i    (s_axis_tdata[21:6]),
    .dominated_size_i (s_axis_tdata[37:22]),
    .row_slot_i       (s_axis_tdata[43:38]),
    .col_slot_i       (s_axis_tdata[49:44]),
    .jaccard_value_i  (s_axis_tdata[65:50]),
    .chosen_ident_o   (chosen_ident),
    .rank_position_o  (rank_position),
    .final_flag_o     (m_axis_tlast)
  );

  a_no_accept_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_pick_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pick |=> m_axis_tvalid)
    else $error("pick did not present a result");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after last result");

endmodule

// ----- verif/maxmin_representative_order_top_tb.sv -----
// Self-checking bench for maxmin_representative_order_top: loads points and
// distances, runs orderings and checks emitted order against a local model.
// Depends on mro_pkg and the block's RTL.
module maxmin_representative_order_top_tb;

  localparam int NP = 64;
  localparam int WD_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [71:0] data;
  } req_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [5:0]  rank;
    logic        last;
  } pick_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  maxmin_representative_order_top dut (.*);

  always #4 clk_i = ~clk_i;

  req_t  pending_q[$];
  pick_t order_q[$];
  int    errors = 0;
  int    idle_cycles = 0;
  int    hold_off = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  bit    stall_pat;
  bit    drain_pause = 0;

  logic [15:0] m_ident[NP];
  logic [15:0] m_size[NP];
  logic [15:0] m_dist[NP*NP];
  int          m_count = 1;

  function automatic bit prefer(int a, int b);
    if (m_size[a] != m_size[b]) return m_size[a] > m_size[b];
    return m_ident[a] < m_ident[b];
  endfunction

  task automatic predict_order();
    bit      taken[NP];
    int      nearest[NP];
    int      n, best, d;
    bit      have;
    pick_t   p;
    n = (m_count > NP) ? NP : m_count;
    for (int i = 0; i < NP; i++) begin
      taken[i] = 0;
      nearest[i] = 32'h10000;
    end
    for (int r = 0; r < n; r++) begin
      have = 0;
      best = 0;
      for (int s = 0; s < n; s++) begin
        if (taken[s]) continue;
        if (!have) begin
          best = s;
          have = 1;
        end else if (r == 0) begin
          if (prefer(s, best)) best = s;
        end else if (nearest[s] > nearest[best] ||
                     (nearest[s] == nearest[best] && prefer(s, best))) begin
          best = s;
        end
      end
      taken[best] = 1;
      for (int s = 0; s < n; s++) begin
        d = int'(m_dist[s*NP+best]);
        if (!taken[s] && d < nearest[s]) nearest[s] = d;
      end
      p.ident = m_ident[best];
      p.rank = r[5:0];
      p.last = (r + 1 == n);
      order_q.push_back(p);
    end
  endtask

  task automatic apply_req(req_t q);
    int v;
    case (q.op)
      mro_pkg::OP_LOAD_POINT: begin
        m_ident[q.data[5:0]] = q.data[21:6];
        m_size[q.data[5:0]] = q.data[37:22];
      end
      mro_pkg::OP_LOAD_DIST: begin
        v = int'(q.data[65:50]);
        if (v > 16'hFFFF) v = 16'hFFFF;
        m_dist[q.data[43:38]*NP + q.data[49:44]] = v[15:0];
      end
      mro_pkg::OP_RUN: predict_order();
      default: ;
    endcase
  endtask

  function automatic req_t mk_point(int slot, int id, int sz);
    req_t q;
    q.op = mro_pkg::OP_LOAD_POINT;
    q.data = '0;
    q.data[5:0] = slot[5:0];
    q.data[21:6] = id[15:0];
    q.data[37:22] = sz[15:0];
    q.data[71:38] = 34'($urandom());
    return q;
  endfunction

  function automatic req_t mk_dist(int r, int c, int v);
    req_t q;
    q.op = mro_pkg::OP_LOAD_DIST;
    q.data = '0;
    q.data[37:0] = 38'({$urandom(), $urandom()});
    q.data[43:38] = r[5:0];
    q.data[49:44] = c[5:0];
    q.data[65:50] = v[15:0];
    q.data[71:66] = 6'($urandom());
    return q;
  endfunction

  function automatic req_t mk_run();
    req_t q;
    q.op = mro_pkg::OP_RUN;
    q.data = 72'({$urandom(), $urandom(), $urandom()});
    return q;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      apply_req(pending_q.pop_front());
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (pending_q.size() == 0 || drain_pause || gap_left > 0 ||
          (s_axis_tvalid && s_axis_tready && pending_q.size() == 0)) begin
        s_axis_tvalid <= 0;
      end else begin
        s_axis_tvalid <= 1;
        s_axis_tuser <= pending_q[0].op;
        s_axis_tdata <= pending_q[0].data;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(12);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(5);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pick_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (order_q.size() == 0) begin
        $display("%0t unexpected result ident=%h rank=%0d last=%b", $time,
                 m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tlast);
        errors++;
      end else begin
        e = order_q.pop_front();
        if (m_axis_tdata[15:0] !== e.ident || m_axis_tdata[21:16] !== e.rank ||
            m_axis_tlast !== e.last) begin
          $display("%0t mismatch expected ident=%h rank=%0d last=%b %s%h rank=%0d last=%b",
                   $time, e.ident, e.rank, e.last, "actual ident=",
                   m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tlast);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      stall_pat = ($urandom_range(9) < 3);
      m_axis_tready <= ($time / 2000) % 3 == 0 ? 1'b1 : !stall_pat;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("maxmin_representative_order_top_tb failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || order_q.size() != 0)
      @(posedge clk_i);
    repeat (2 * NP * NP + 4 * NP) @(posedge clk_i);
  endtask

  task automatic set_count(int n);
    wait_drained();
    cfg_data_i <= n[6:0];
    cfg_valid_i <= 1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    m_count = n;
  endtask

  // load n points and full n x n matrix, then run
  task automatic queue_set(int n, bit zero_sizes, bit ties);
    int base;
    base = $urandom_range(65535 - n);
    for (int s = 0; s < n; s++)
      pending_q.push_back(mk_point(s, (base + s * 7) % 65536 == 0 ? s : base + s,
                          zero_sizes ? 0 : (ties ? $urandom_range(1) :
                          $urandom_range(65535))));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        pending_q.push_back(mk_dist(r, c, ties ? 16384 * $urandom_range(2) :
                            ($urandom_range(7) == 0 ? 32768 : $urandom_range(32768))));
    if ($urandom_range(9) == 0) begin
      req_t j;
      j = mk_run();
      j.op = 2'd3;
      pending_q.push_back(j);
    end
    pending_q.push_back(mk_run());
  endtask

  initial begin
    int n;
    for (int i = 0; i < NP; i++) begin
      m_ident[i] = 0;
      m_size[i] = 0;
    end
    for (int i = 0; i < NP * NP; i++) m_dist[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: count 1 with extremes, then counts 0, 3 and 2
    pending_q.push_back(mk_point(0, 16'hFFFF, 16'hFFFF));
    pending_q.push_back(mk_dist(0, 0, 32768));
    pending_q.push_back(mk_run());
    wait_drained();
    set_count(0);
    pending_q.push_back(mk_run());
    set_count(3);
    pending_q.push_back(mk_point(0, 16'h0000, 0));
    pending_q.push_back(mk_point(1, 16'h8000, 0));
    pending_q.push_back(mk_point(2, 16'h0001, 0));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) pending_q.push_back(mk_dist(r, c, 0));
    pending_q.push_back(mk_run());
    set_count(2);
    pending_q.push_back(mk_point(63, 5, 9));
    pending_q.push_back(mk_dist(63, 63, 1));
    pending_q.push_back(mk_run());

    // hold off the receiver while a second set keeps offering requests
    set_count(8);
    queue_set(8, 0, 0);
    queue_set(8, 0, 1);
    hold_off = 3000;

    // random phases with small sets
    for (int ph = 0; ph < 9; ph++) begin
      n = $urandom_range(1, 5);
      if (ph == 8) n = 1;
      set_count(n);
      for (int k = 0; k < 2; k++) queue_set(n, $urandom_range(5) == 0,
                                            $urandom_range(2) == 0);
      if (ph == 5) begin
        while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        drain_pause = 1;
        queue_set(n, 0, 0);
        while (order_q.size() != 0) @(posedge clk_i);
        drain_pause = 0;
      end
    end
    wait_drained();
    if (errors == 0)
      $display("maxmin_representative_order_top_tb passed");
    else
      $display("maxmin_representative_order_top_tb failed");
    $finish;
  end
endmodule
